// ----- rtl/rauc_pkg.sv -----
// ----------------------------------------------------------------------------
// rauc_pkg: shared types and constants for the rank-sum AUC block
// Holds the controller state type, command/status structs and field widths.
// ----------------------------------------------------------------------------
package rauc_pkg;

    localparam int MAX_ITEMS_DEF = 1024;
    localparam int SCORE_W       = 32;
    localparam int CNT_OUT_W     = 11;
    localparam int AUC_W         = 17;
    localparam int STATUS_W      = 2;
    localparam int DIV_Q_W       = 17;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_POS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_NEG  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd3;

    typedef enum logic [3:0] {
        S_LOAD,
        S_OUTER_RD,
        S_OUTER_WAIT,
        S_INNER,
        S_INNER_LAST,
        S_ACCUM,
        S_PREP,
        S_MUL,
        S_DIV,
        S_RESULT
    } rauc_state_t;

    // controller -> datapath
    typedef struct packed {
        logic store_item;   // write accepted beat into the store
        logic clr_set;      // clear counts for a new set
        logic set_drop;     // flag dropped item
        logic outer_start;  // outer index to zero, clear sum
        logic outer_rd;     // read outer entry
        logic outer_latch;  // latch outer key/label
        logic inner_start;  // inner index to zero, clear below/equal
        logic inner_step;   // compare one entry, advance inner index
        logic accum;        // add doubled rank, advance outer index
        logic prep;         // form numerator and denominator factors
        logic mul;          // register products
        logic div_step;     // one quotient bit
    } rauc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;         // store holds MAX_ITEMS
        logic outer_done;   // outer index reached item count
        logic outer_pos;    // latched outer label
        logic inner_done;   // inner index at last entry
        logic div_done;     // last quotient bit being formed
    } rauc_stat_t;

endpackage

// ----- rtl/rank_auc_metric.sv -----
// ----------------------------------------------------------------------------
// rank_auc_metric: ROC AUC by the Mann-Whitney rank sum
// Stores a set of scored, labeled items and reports the AUC of the set.
// ----------------------------------------------------------------------------
// Input beats (s_*) carry score, label and last. While the block is loading,
// beats are taken one per cycle and written to the item store, the last beat
// too; a beat beyond MAX_ITEMS is dropped and the result status reports it.
// After the last beat the block stops taking input and ranks the set: for
// each stored item one store read, and for each positive a full sweep of the
// set through the single store read port. A restoring divider that forms 17
// quotient bits follows, then one result beat is loaded into the output
// register. Input is taken again once the result is loaded.
// If the receiver stalls, the result waits in the output register and the
// block accepts the next set's items meanwhile; the following result waits
// until the register is free.
// Reset (aresetn low, synchronous) empties the set and the output register.
// The store needs no clearing; only written entries are read.
// ----------------------------------------------------------------------------
module rank_auc_metric
    import rauc_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SCORE_W-1:0]  s_score,
    input  logic                       s_is_positive,
    input  logic                       s_last,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [AUC_W-1:0]           m_auc_q16,
    output logic [CNT_OUT_W-1:0]       m_positives,
    output logic [CNT_OUT_W-1:0]       m_negatives,
    output logic [STATUS_W-1:0]        m_status
);

    rauc_cmd_t  cmd;
    rauc_stat_t stat;
    logic       out_load, out_free;
    logic [AUC_W-1:0]     res_auc;
    logic [CNT_OUT_W-1:0] res_pos, res_neg;
    logic [STATUS_W-1:0]  res_status;
    logic                 valid_reg;
    logic [AUC_W-1:0]     auc_reg;
    logic [CNT_OUT_W-1:0] pos_reg, neg_reg;
    logic [STATUS_W-1:0]  status_reg;

    rauc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_last   (s_last),
        .out_load (out_load),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    rauc_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_score       (s_score),
        .s_is_positive (s_is_positive),
        .cmd           (cmd),
        .stat          (stat),
        .res_auc       (res_auc),
        .res_pos       (res_pos),
        .res_neg       (res_neg),
        .res_status    (res_status)
    );

    // output register
    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
        if (out_load) begin
            auc_reg    <= res_auc;
            pos_reg    <= res_pos;
            neg_reg    <= res_neg;
            status_reg <= res_status;
        end
    end

    assign m_valid     = valid_reg;
    assign m_auc_q16   = auc_reg;
    assign m_positives = pos_reg;
    assign m_negatives = neg_reg;
    assign m_status    = status_reg;

endmodule

// ----- rtl/rauc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rauc_ctrl: sequencing state machine
// Loads items, then runs the ranking passes, the product and divide steps.
// ----------------------------------------------------------------------------
module rauc_ctrl
    import rauc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_last,
    output logic       out_load,
    input  logic       out_free,
    input  rauc_stat_t stat,
    output rauc_cmd_t  cmd
);

    rauc_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.store_item = !stat.full;
                    cmd.set_drop   = stat.full;
                    if (s_last) begin
                        cmd.outer_start = 1'b1;
                        state_next      = S_OUTER_RD;
                    end
                end
            end
            S_OUTER_RD: begin
                if (stat.outer_done) begin
                    state_next = S_PREP;
                end else begin
                    cmd.outer_rd = 1'b1;
                    state_next   = S_OUTER_WAIT;
                end
            end
            S_OUTER_WAIT: begin
                cmd.outer_latch = 1'b1;
                cmd.inner_start = 1'b1;
                state_next      = S_INNER;
            end
            S_INNER: begin
                if (!stat.outer_pos) begin
                    cmd.accum  = 1'b1;
                    state_next = S_OUTER_RD;
                end else begin
                    cmd.inner_step = 1'b1;
                    if (stat.inner_done) begin
                        state_next = S_INNER_LAST;
                    end
                end
            end
            S_INNER_LAST: begin
                // last compare lands in the cycle after its read
                cmd.inner_step = 1'b1;
                state_next     = S_ACCUM;
            end
            S_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = S_OUTER_RD;
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    cmd.clr_set  = 1'b1;
                    out_load     = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

// ----- rtl/rauc_dp.sv -----
// ----------------------------------------------------------------------------
// rauc_dp: item store, rank counters, products and restoring divider
// One store read per cycle; rank of a positive is counted over the whole set.
// ----------------------------------------------------------------------------
module rauc_dp
    import rauc_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic signed [SCORE_W-1:0]   s_score,
    input  logic                        s_is_positive,
    input  rauc_cmd_t                   cmd,
    output rauc_stat_t                  stat,
    output logic [AUC_W-1:0]            res_auc,
    output logic [CNT_OUT_W-1:0]        res_pos,
    output logic [CNT_OUT_W-1:0]        res_neg,
    output logic [STATUS_W-1:0]         res_status
);

    localparam int AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW   = $clog2(MAX_ITEMS + 1);
    localparam int SW   = 2 * CW + 2;           // doubled rank sum
    localparam int PW   = 2 * CW + 1;           // products
    localparam int NUMW = SW + 16;              // shifted numerator
    localparam int QCW  = $clog2(DIV_Q_W + 1);

    // store
    logic [SCORE_W-1:0] score_mem [MAX_ITEMS];
    logic               label_mem [MAX_ITEMS];
    logic [SCORE_W-1:0] rd_score_reg;
    logic               rd_label_reg;

    logic [CW-1:0] count_reg, pos_reg;
    logic          drop_reg;
    logic [CW-1:0] outer_reg, inner_reg;
    logic [SCORE_W-1:0] key_reg;
    logic          opos_reg;
    logic [CW-1:0] below_reg, equal_reg;
    logic          cmp_vld_reg;
    logic [SW-1:0] sum_reg;
    logic [CW-1:0] p_reg, n_reg;
    logic [PW-1:0] pp1_reg, den_reg;
    logic [NUMW-1:0] rem_reg;
    logic [NUMW-1:0] dsh_reg;
    logic [DIV_Q_W-1:0] q_reg;
    logic [QCW-1:0] qcnt_reg;

    logic [AW-1:0] rd_addr;
    logic [SCORE_W-1:0] okey, ikey;

    // read address: outer read or inner sweep
    always_comb begin
        rd_addr = cmd.outer_rd ? outer_reg[AW-1:0] : inner_reg[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_item) begin
            score_mem[count_reg[AW-1:0]] <= s_score;
            label_mem[count_reg[AW-1:0]] <= s_is_positive;
        end
        rd_score_reg <= score_mem[rd_addr];
        rd_label_reg <= label_mem[rd_addr];
    end

    assign okey = key_reg ^ {1'b1, {(SCORE_W-1){1'b0}}};
    assign ikey = rd_score_reg ^ {1'b1, {(SCORE_W-1){1'b0}}};

    // set counters
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_set) begin
            count_reg <= '0;
            pos_reg   <= '0;
            drop_reg  <= 1'b0;
        end else begin
            if (cmd.store_item) begin
                count_reg <= count_reg + 1'b1;
                pos_reg   <= pos_reg + CW'(s_is_positive);
            end
            if (cmd.set_drop) begin
                drop_reg <= 1'b1;
            end
        end
    end

    // rank passes
    always_ff @(posedge aclk) begin
        if (cmd.outer_start) begin
            outer_reg <= '0;
            sum_reg   <= '0;
        end
        if (cmd.outer_latch) begin
            key_reg  <= rd_score_reg;
            opos_reg <= rd_label_reg;
        end
        if (cmd.inner_start) begin
            inner_reg   <= '0;
            below_reg   <= '0;
            equal_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end
        if (cmd.inner_step) begin
            if (!stat.inner_done) begin
                inner_reg <= inner_reg + 1'b1;
            end
            cmp_vld_reg <= 1'b1;
            if (cmp_vld_reg) begin
                if (ikey < okey) begin
                    below_reg <= below_reg + 1'b1;
                end else if (ikey == okey) begin
                    equal_reg <= equal_reg + 1'b1;
                end
            end
        end
        if (cmd.accum) begin
            outer_reg <= outer_reg + 1'b1;
            if (opos_reg) begin
                sum_reg <= sum_reg + {below_reg, 1'b0} + SW'(equal_reg) + SW'(1);
            end
        end
    end

    // products and divider
    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            p_reg <= pos_reg;
            n_reg <= count_reg - pos_reg;
        end
        if (cmd.mul) begin
            // operands widened first so p+1 and the products never wrap
            pp1_reg  <= PW'(p_reg) * (PW'(p_reg) + PW'(1));
            den_reg  <= PW'({p_reg, 1'b0}) * PW'(n_reg);
            qcnt_reg <= '0;
            q_reg    <= '0;
        end
        if (cmd.div_step) begin
            if (qcnt_reg == '0) begin
                rem_reg <= {NUMW'(sum_reg - SW'(pp1_reg)) << 16};
                dsh_reg <= NUMW'(den_reg) << 16;
            end else begin
                if (rem_reg >= dsh_reg) begin
                    rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[DIV_Q_W-2:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[DIV_Q_W-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
            end
            qcnt_reg <= qcnt_reg + 1'b1;
        end
    end

    assign stat.full       = (count_reg == CW'(MAX_ITEMS));
    assign stat.outer_done = (outer_reg == count_reg);
    assign stat.outer_pos  = opos_reg;
    assign stat.inner_done = (inner_reg == count_reg - 1'b1);
    assign stat.div_done   = (qcnt_reg == QCW'(DIV_Q_W));

    // result (valid while in result state)
    always_comb begin
        res_pos = CNT_OUT_W'(p_reg);
        res_neg = CNT_OUT_W'(n_reg);
        res_auc = '0;
        if (p_reg == '0) begin
            res_status = ST_NO_POS;
        end else if (n_reg == '0) begin
            res_status = ST_NO_NEG;
        end else begin
            res_status = ST_OK;
            res_auc    = (q_reg > DIV_Q_W'(65536)) ? AUC_W'(65536) : AUC_W'(q_reg);
        end
        if (drop_reg) begin
            res_status = ST_DROPPED;
        end
    end

endmodule

// ----- rtl/rauc_checker.sv -----
// ----------------------------------------------------------------------------
// rauc_checker: port-level checks for rank_auc_metric
// Watches the result channel and the input stall after a last beat.
// ----------------------------------------------------------------------------
module rauc_checker
    import rauc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 s_last,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [AUC_W-1:0]     m_auc_q16,
    input logic [STATUS_W-1:0]  m_status
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_auc_q16) && $stable(m_status))
        else $error("result beat changed under stall");

    // AUC never above one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_auc_q16 <= AUC_W'(65536))
        else $error("auc above 1.0");

    // a degenerate set reports zero AUC
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_NO_POS || m_status == ST_NO_NEG) |-> m_auc_q16 == '0)
        else $error("nonzero auc with empty class");

    // input pauses after a last beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("input taken during ranking");

endmodule

bind rank_auc_metric rauc_checker u_rauc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_last    (s_last),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_auc_q16 (m_auc_q16),
    .m_status  (m_status)
);
